// ===== design/rank_normalizer_assert.svh =====
// ----------------------------------------------------------------------------
// Rank normaliser assertion macros
// Shared property templates for the checker of the rank normaliser.
// ----------------------------------------------------------------------------
`ifndef RANK_NORMALIZER_ASSERT_SVH
`define RANK_NORMALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rn_pkg.sv =====
// ----------------------------------------------------------------------------
// Rank normaliser package
// Field widths shared by the rank normaliser and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rn_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 7;

endpackage

`default_nettype wire

// ===== design/rank_normalizer.sv =====
// Loading: a sequence of n values loads at one request per cycle; the request
// flagged last starts the burst, and each rank is then found by comparing every
// value through the second memory read port, then a finishing and an output state.
// Input stays stalled until the last rank is taken; the single compare port sets the pace.
// Reset: control state returns to loading with an empty store; the memory itself
// is not cleared.
`default_nettype none

// ----------------------------------------------------------------------------
// Rank normaliser
// Stores a sequence of signed values and returns each value's 1-based rank.
// ----------------------------------------------------------------------------
module rank_normalizer #(
  parameter int MAX_COUNT = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rn_pkg::VALUE_W-1:0]   in_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [rn_pkg::RANK_W-1:0]    out_rank,
  output logic                                out_last_rank
);

  import rn_pkg::*;

  localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t                    state_r;
  logic         [CW-1:0]     count_r;
  logic         [AW-1:0]     pos_r;
  logic         [AW-1:0]     k_r;
  logic         [CW-1:0]     smaller_r;
  logic                      cmp_v_r;
  logic                      out_valid_r;
  logic         [RANK_W-1:0] out_rank_r;
  logic                      out_last_r;

  logic signed [VALUE_W-1:0] mem [MAX_COUNT];
  logic signed [VALUE_W-1:0] rd_a_r;
  logic signed [VALUE_W-1:0] rd_b_r;

  logic                      in_accept;
  logic                      wr_en;
  logic                      hit;
  logic                      k_last;
  logic                      pos_last;
  logic         [RANK_W-1:0] rank_nxt;

  assign in_stall  = (state_r != S_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign wr_en     = in_accept && (count_r < CW'(MAX_COUNT));
  assign hit       = cmp_v_r && (rd_b_r < rd_a_r);
  assign k_last    = ((CW'(k_r) + CW'(1)) == count_r);
  assign pos_last  = ((CW'(pos_r) + CW'(1)) == count_r);
  assign rank_nxt  = RANK_W'(smaller_r) + RANK_W'(hit) + RANK_W'(1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= in_value;
    end
    rd_a_r <= mem[pos_r];
    rd_b_r <= mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      smaller_r   <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_v_r <= (state_r == S_SCAN);
      if (hit) begin
        smaller_r <= smaller_r + CW'(1);
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_accept) begin
            if (wr_en) begin
              count_r <= count_r + CW'(1);
            end
            if (in_last) begin
              state_r   <= S_SCAN;
              pos_r     <= '0;
              k_r       <= '0;
              smaller_r <= '0;
            end
          end
        end
        S_SCAN: begin
          k_r <= k_r + AW'(1);
          if (k_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          out_valid_r <= 1'b1;
          out_rank_r  <= rank_nxt;
          out_last_r  <= pos_last;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_LOAD;
              count_r <= '0;
            end else begin
              pos_r     <= pos_r + AW'(1);
              k_r       <= '0;
              smaller_r <= '0;
              state_r   <= S_SCAN;
            end
          end
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rank      = out_rank_r;
  assign out_last_rank = out_last_r;

endmodule

`default_nettype wire

// ===== design/rn_checker.sv =====
// ----------------------------------------------------------------------------
// Rank normaliser checker
// Port-level checks on the rank normaliser, bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rank_normalizer_assert.svh"

module rn_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rn_pkg::RANK_W-1:0]     out_rank,
  input logic                          out_last_rank
);

  import rn_pkg::*;

  `RN_ASSERT_IMP(a_busy_while_out, clk, rst_n, out_valid, in_stall, "input taken during a burst")
  `RN_ASSERT_IMP(a_rank_nonzero, clk, rst_n, out_valid, out_rank != RANK_W'(0), "rank of zero")
  `RN_ASSERT_NXT(a_gap_after_out, clk, rst_n, out_valid && !out_stall, !out_valid, "results back to back")
  `RN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_rank) && $stable(out_last_rank), "stalled request changed")

endmodule

bind rank_normalizer rn_checker u_rn_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_rank      (out_rank),
  .out_last_rank (out_last_rank)
);

`default_nettype wire
